/* rtl/iee_pkg.sv */
// Shared types, codes and helpers for the infix expression evaluator.
package iee_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  localparam logic [2:0] OP_LPAR = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DIVZERO = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_MALFORMED = 2'd3;

  localparam logic [7:0] CH_LPAR = 8'h28;
  localparam logic [7:0] CH_RPAR = 8'h29;
  localparam logic [7:0] CH_MUL = 8'h2A;
  localparam logic [7:0] CH_ADD = 8'h2B;
  localparam logic [7:0] CH_SUB = 8'h2D;
  localparam logic [7:0] CH_DIV = 8'h2F;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Datapath commands.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_DIGIT,
    CMD_PUSH_ACC,
    CMD_PUSH_OP,
    CMD_POP_OP,
    CMD_READ_NUMS,
    CMD_EXEC,
    CMD_DIV_START,
    CMD_PUSH_RES,
    CMD_READ_FINAL,
    CMD_CLEAR
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [2:0] op;
    logic [7:0] sym;
  } ctrl_t;

  typedef struct packed {
    logic [SP_W-1:0] num_top;
    logic [SP_W-1:0] op_top;
    logic [2:0]      op_rd;
    logic            digit_pending;
    logic            div_busy;
    logic            div_zero;
  } stat_t;

  function automatic logic [1:0] rank(input logic [2:0] op);
    if (op == OP_ADD || op == OP_SUB) return 2'd1;
    if (op == OP_MUL || op == OP_DIV) return 2'd2;
    return 2'd0;
  endfunction

endpackage

/* rtl/infix_expression_evaluator.sv */
// Top level of the infix expression evaluator.
// Characters arrive one word at a time; a digit or ignored character is
// handled in the dispatch step, while an operator or close parenthesis runs
// the operator-pop loop in the controller, and a division also waits for
// the bit-serial divider. The
// word with tlast set is followed by a flush of the operator stack and one
// result word. Stacks hold STACK_DEPTH entries each and need no clearing.
module infix_expression_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // symbol
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // value [31:0], status [33:32], zero fill
);
  import iee_pkg::*;

  ctrl_t       ctrl;
  stat_t       stat;
  logic [31:0] rd;
  logic [1:0]  status;

  iee_control u_ctl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_sym(in_tdata), .in_last(in_tlast), .out_valid(out_tvalid),
    .out_ready(out_tready), .out_status(status), .ctrl(ctrl), .stat(stat)
  );

  iee_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat), .result(rd)
  );

  assign out_tdata = {6'd0, status, (status == ST_OK) ? rd : 32'd0};

  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input and output both open");
  a_num_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.num_top <= SP_W'(STACK_DEPTH)) else $error("number stack overrun");
  a_op_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.op_top <= SP_W'(STACK_DEPTH)) else $error("operator stack overrun");
endmodule

/* rtl/iee_divider.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module iee_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt, busy_r, busy_nxt;
  logic [32:0] trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    busy_nxt = busy_r;
    trial = {rem_r, quo_r[31]} - {1'b0, den_r};
    if (start) begin
      rem_nxt = 32'd0;
      quo_nxt = dividend[31] ? 32'd0 - dividend : dividend;
      den_nxt = divisor[31] ? 32'd0 - divisor : divisor;
      neg_nxt = dividend[31] ^ divisor[31];
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign busy = busy_r;
  assign quotient = neg_r ? 32'd0 - quo_r : quo_r;
endmodule

/* rtl/iee_datapath.sv */
// Stacks, digit accumulator and arithmetic of the expression evaluator.
module iee_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  iee_pkg::ctrl_t  ctrl,
  output iee_pkg::stat_t  stat,
  output logic [31:0]     result
);
  import iee_pkg::*;

  logic [31:0] num_mem [STACK_DEPTH];
  logic [2:0]  op_mem [STACK_DEPTH];
  logic [SP_W-1:0] num_top_r, num_top_nxt, op_top_r, op_top_nxt;
  logic [31:0] acc_r, acc_nxt, left_r, right_r, res_r, rd_r;
  logic        pend_r, pend_nxt, rd_sel_r;
  logic [2:0]  op_rd_r;
  logic        div_start, div_busy;
  logic [31:0] quo;
  logic [IDX_W-1:0] nidx, oidx, raddr;
  logic [31:0] wdata;

  iee_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(left_r),
    .divisor(right_r), .busy(div_busy), .quotient(quo)
  );

  assign div_start = (ctrl.cmd == CMD_DIV_START);
  assign nidx = num_top_r[IDX_W-1:0];
  assign oidx = op_top_r[IDX_W-1:0];
  assign raddr = (ctrl.cmd == CMD_READ_FINAL) ? '0 : nidx - IDX_W'(1);
  assign wdata = (ctrl.cmd == CMD_PUSH_ACC) ? acc_r : ((ctrl.op == OP_DIV) ? quo : res_r);

  always_comb begin
    num_top_nxt = num_top_r;
    op_top_nxt = op_top_r;
    acc_nxt = acc_r;
    pend_nxt = pend_r;
    unique case (ctrl.cmd)
      CMD_DIGIT: begin
        acc_nxt = (acc_r << 3) + (acc_r << 1) + {24'd0, ctrl.sym - CH_ZERO};
        pend_nxt = 1'b1;
      end
      CMD_PUSH_ACC: begin
        num_top_nxt = num_top_r + SP_W'(1);
        acc_nxt = 32'd0;
        pend_nxt = 1'b0;
      end
      CMD_PUSH_OP: op_top_nxt = op_top_r + SP_W'(1);
      CMD_POP_OP: op_top_nxt = op_top_r - SP_W'(1);
      CMD_READ_NUMS: num_top_nxt = num_top_r - SP_W'(2);
      CMD_PUSH_RES: num_top_nxt = num_top_r + SP_W'(1);
      CMD_CLEAR: begin
        num_top_nxt = '0;
        op_top_nxt = '0;
        acc_nxt = 32'd0;
        pend_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_top_r <= '0;
      op_top_r <= '0;
      acc_r <= 32'd0;
      pend_r <= 1'b0;
    end else begin
      num_top_r <= num_top_nxt;
      op_top_r <= op_top_nxt;
      acc_r <= acc_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Stack memories: the top entries are read into registers, the right operand first, then the left.
  always_ff @(posedge clk) begin
    if (ctrl.cmd == CMD_PUSH_ACC || ctrl.cmd == CMD_PUSH_RES) num_mem[nidx] <= wdata;
    if (ctrl.cmd == CMD_PUSH_OP) op_mem[oidx] <= ctrl.op;
    op_rd_r <= op_mem[oidx - IDX_W'(1)];
    if (ctrl.cmd == CMD_READ_FINAL) rd_r <= num_mem[raddr];
    rd_sel_r <= (ctrl.cmd == CMD_READ_NUMS);
    if (ctrl.cmd == CMD_READ_NUMS) right_r <= num_mem[raddr];
    if (rd_sel_r) left_r <= num_mem[nidx];
    if (ctrl.cmd == CMD_EXEC) begin
      unique case (ctrl.op)
        OP_ADD: res_r <= left_r + right_r;
        OP_SUB: res_r <= left_r - right_r;
        OP_MUL: res_r <= left_r * right_r;
        default: res_r <= 32'd0;
      endcase
    end
  end

  assign stat = '{num_top: num_top_r, op_top: op_top_r, op_rd: op_rd_r,
                  digit_pending: pend_r, div_busy: div_busy,
                  div_zero: (right_r == 32'd0)};
  assign result = rd_r;
endmodule

/* rtl/iee_control.sv */
// Sequencer that walks the shunting-yard steps for each incoming character.
module iee_control (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_sym,
  input  logic            in_last,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_status,
  output iee_pkg::ctrl_t  ctrl,
  input  iee_pkg::stat_t  stat
);
  import iee_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DISP   = 11'b00000000010,
    S_PEEK   = 11'b00000000100,
    S_LOOP   = 11'b00000001000,
    S_RD1    = 11'b00000010000,
    S_RD2    = 11'b00000100000,
    S_EXEC   = 11'b00001000000,
    S_DIVW   = 11'b00010000000,
    S_PUSH   = 11'b00100000000,
    S_FIN    = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  // mode: what is done after an operator pop loop finishes.
  typedef enum logic [1:0] {M_OPER, M_CLOSE, M_FLUSH} mode_t;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic [7:0] sym_r, sym_nxt;
  logic       last_r, last_nxt, fin_r, fin_nxt;
  logic [2:0] cur_r, cur_nxt, ap_r, ap_nxt;
  logic [1:0] err_r, err_nxt;
  logic        is_digit, is_op;
  logic [2:0]  sym_op;

  assign is_digit = (sym_r >= CH_ZERO) && (sym_r <= CH_NINE);
  always_comb begin
    is_op = 1'b1;
    sym_op = OP_LPAR;
    unique case (sym_r)
      CH_ADD: sym_op = OP_ADD;
      CH_SUB: sym_op = OP_SUB;
      CH_MUL: sym_op = OP_MUL;
      CH_DIV: sym_op = OP_DIV;
      default: is_op = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt = mode_r;
    sym_nxt = sym_r;
    last_nxt = last_r;
    fin_nxt = fin_r;
    cur_nxt = cur_r;
    ap_nxt = ap_r;
    err_nxt = err_r;
    ctrl = '{cmd: CMD_NONE, op: ap_r, sym: sym_r};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sym_nxt = in_sym;
          last_nxt = in_last;
          fin_nxt = 1'b0;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (err_r != ST_OK) begin
          state_nxt = last_r ? S_PEEK : S_IDLE;
          fin_nxt = 1'b1;
          mode_nxt = M_FLUSH;
        end else if (fin_r) begin
          // End of expression: push pending literal, then flush.
          if (stat.digit_pending) begin
            if (stat.num_top == SP_W'(STACK_DEPTH)) err_nxt = ST_OVERFLOW;
            else ctrl.cmd = CMD_PUSH_ACC;
          end
          mode_nxt = M_FLUSH;
          state_nxt = S_PEEK;
        end else if (is_digit) begin
          ctrl.cmd = CMD_DIGIT;
          state_nxt = last_r ? S_DISP : S_IDLE;
          fin_nxt = last_r;
        end else if (stat.digit_pending) begin
          if (stat.num_top == SP_W'(STACK_DEPTH)) begin
            err_nxt = ST_OVERFLOW;
            ctrl.cmd = CMD_CLEAR;
          end else begin
            ctrl.cmd = CMD_PUSH_ACC;
          end
        end else if (sym_r == CH_LPAR || (is_op && stat.op_top == '0)) begin
          if (stat.op_top == SP_W'(STACK_DEPTH)) err_nxt = ST_OVERFLOW;
          else begin
            ctrl.cmd = CMD_PUSH_OP;
            ctrl.op = (sym_r == CH_LPAR) ? OP_LPAR : sym_op;
          end
          state_nxt = last_r ? S_DISP : S_IDLE;
          fin_nxt = last_r;
        end else if (is_op || sym_r == CH_RPAR) begin
          cur_nxt = sym_op;
          mode_nxt = is_op ? M_OPER : M_CLOSE;
          state_nxt = S_PEEK;
        end else begin
          state_nxt = last_r ? S_DISP : S_IDLE;
          fin_nxt = last_r;
        end
      end
      S_PEEK: state_nxt = S_LOOP;  // operator top read settles
      S_LOOP: begin
        ap_nxt = stat.op_rd;
        if (err_r != ST_OK) begin
          state_nxt = (mode_r == M_FLUSH) ? S_FIN : (last_r ? S_DISP : S_IDLE);
          fin_nxt = 1'b1;
        end else if (stat.op_top == '0) begin
          unique case (mode_r)
            M_CLOSE: begin
              err_nxt = ST_MALFORMED;
              state_nxt = last_r ? S_DISP : S_IDLE;
              fin_nxt = 1'b1;
            end
            M_OPER: begin
              ctrl.cmd = CMD_PUSH_OP;
              ctrl.op = cur_r;
              state_nxt = last_r ? S_DISP : S_IDLE;
              fin_nxt = 1'b1;
            end
            default: state_nxt = S_FIN;
          endcase
        end else if (mode_r == M_OPER && rank(cur_r) > rank(stat.op_rd)) begin
          if (stat.op_top == SP_W'(STACK_DEPTH)) err_nxt = ST_OVERFLOW;
          else begin
            ctrl.cmd = CMD_PUSH_OP;
            ctrl.op = cur_r;
          end
          state_nxt = last_r ? S_DISP : S_IDLE;
          fin_nxt = 1'b1;
        end else begin
          ctrl.cmd = CMD_POP_OP;
          if (stat.op_rd == OP_LPAR) begin
            if (mode_r == M_FLUSH) begin
              err_nxt = ST_MALFORMED;
              state_nxt = S_FIN;
            end else begin
              state_nxt = last_r ? S_DISP : S_IDLE;
              fin_nxt = 1'b1;
            end
          end else if (stat.num_top < SP_W'(2)) begin
            err_nxt = ST_MALFORMED;
            state_nxt = S_PEEK;
          end else begin
            state_nxt = S_RD1;
          end
        end
      end
      S_RD1: begin
        ctrl.cmd = CMD_READ_NUMS;
        state_nxt = S_RD2;
      end
      S_RD2: state_nxt = S_EXEC;
      S_EXEC: begin
        if (ap_r == OP_DIV) begin
          if (stat.div_zero) begin
            err_nxt = ST_DIVZERO;
            state_nxt = S_PEEK;
          end else begin
            ctrl.cmd = CMD_DIV_START;
            state_nxt = S_DIVW;
          end
        end else begin
          ctrl.cmd = CMD_EXEC;
          state_nxt = S_PUSH;
        end
      end
      S_DIVW: if (!stat.div_busy) state_nxt = S_PUSH;
      S_PUSH: begin
        ctrl.cmd = CMD_PUSH_RES;
        state_nxt = S_PEEK;
      end
      S_FIN: begin
        if (err_r == ST_OK && stat.num_top != SP_W'(1)) err_nxt = ST_MALFORMED;
        ctrl.cmd = CMD_READ_FINAL;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          ctrl.cmd = CMD_CLEAR;
          err_nxt = ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      err_r <= ST_OK;
      fin_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      err_r <= err_nxt;
      fin_r <= fin_nxt;
    end
    mode_r <= mode_nxt;
    sym_r <= sym_nxt;
    last_r <= last_nxt;
    cur_r <= cur_nxt;
    ap_r <= ap_nxt;
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status = err_r;
endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the infix expression evaluator.
module tb;
  import iee_pkg::*;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
  } char_word_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  infix_expression_evaluator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  char_word_t pending_chars[$];
  answer_t    expected_answers[$];
  int         fail_count;
  int         cycle_count;
  bit         stimulus_done;
  bit         calm_phase;
  int         hold_cycles;

  // Predictor state.
  logic [31:0] p_nums[STACK_DEPTH];
  int          p_ntop;
  logic [2:0]  p_ops[STACK_DEPTH];
  int          p_otop;
  logic [31:0] p_acc;
  bit          p_digit;
  logic [1:0]  p_err;

  function automatic int op_rank(logic [2:0] op);
    if (op == OP_ADD || op == OP_SUB) return 1;
    if (op == OP_MUL || op == OP_DIV) return 2;
    return 0;
  endfunction

  task automatic eval_clear();
    p_ntop = 0;
    p_otop = 0;
    p_acc = '0;
    p_digit = 0;
    p_err = ST_OK;
  endtask

  task automatic flag_error(logic [1:0] code);
    if (p_err == ST_OK) p_err = code;
  endtask

  task automatic push_num(logic [31:0] v);
    if (p_ntop >= STACK_DEPTH) flag_error(ST_OVERFLOW);
    else begin
      p_nums[p_ntop] = v;
      p_ntop++;
    end
  endtask

  task automatic push_op(logic [2:0] op);
    if (p_otop >= STACK_DEPTH) flag_error(ST_OVERFLOW);
    else begin
      p_ops[p_otop] = op;
      p_otop++;
    end
  endtask

  task automatic apply_op(logic [2:0] op);
    logic [31:0] l, r, res, ua, ub, q;
    if (p_ntop < 2) begin
      flag_error(ST_MALFORMED);
      return;
    end
    r = p_nums[p_ntop-1];
    l = p_nums[p_ntop-2];
    p_ntop -= 2;
    res = '0;
    case (op)
      OP_ADD: res = l + r;
      OP_SUB: res = l - r;
      OP_MUL: res = l * r;
      OP_DIV: begin
        if (r == 0) flag_error(ST_DIVZERO);
        else begin
          ua = l[31] ? -l : l;
          ub = r[31] ? -r : r;
          q = ua / ub;
          res = (l[31] != r[31]) ? -q : q;
        end
      end
      default: flag_error(ST_MALFORMED);
    endcase
    push_num(res);
  endtask

  task automatic handle_binary(logic [2:0] op);
    logic [2:0] prev;
    if (p_otop == 0) begin
      push_op(op);
      return;
    end
    while (p_otop > 0 && p_err == ST_OK) begin
      prev = p_ops[p_otop-1];
      if (op_rank(op) > op_rank(prev)) break;
      p_otop--;
      apply_op(prev);
    end
    if (p_err == ST_OK) push_op(op);
  endtask

  task automatic handle_close();
    logic [2:0] prev;
    forever begin
      if (p_err != ST_OK) return;
      if (p_otop == 0) begin
        flag_error(ST_MALFORMED);
        return;
      end
      prev = p_ops[p_otop-1];
      p_otop--;
      if (prev == OP_LPAR) return;
      apply_op(prev);
    end
  endtask

  task automatic eval_char(char_word_t w);
    answer_t a;
    logic [2:0] op;
    if (p_err == ST_OK) begin
      if (w.sym >= CH_ZERO && w.sym <= CH_NINE) begin
        p_acc = p_acc * 10 + 32'(w.sym - CH_ZERO);
        p_digit = 1;
      end else begin
        if (p_digit) begin
          push_num(p_acc);
          p_digit = 0;
          p_acc = '0;
        end
        if (p_err == ST_OK) begin
          case (w.sym)
            CH_LPAR: push_op(OP_LPAR);
            CH_RPAR: handle_close();
            CH_ADD:  handle_binary(OP_ADD);
            CH_SUB:  handle_binary(OP_SUB);
            CH_MUL:  handle_binary(OP_MUL);
            CH_DIV:  handle_binary(OP_DIV);
            default: ;
          endcase
        end
      end
    end
    if (!w.last) return;
    if (p_err == ST_OK && p_digit) begin
      push_num(p_acc);
      p_digit = 0;
    end
    while (p_err == ST_OK && p_otop > 0) begin
      op = p_ops[p_otop-1];
      p_otop--;
      if (op == OP_LPAR) flag_error(ST_MALFORMED);
      else apply_op(op);
    end
    a.value = '0;
    if (p_err == ST_OK) begin
      if (p_ntop != 1) flag_error(ST_MALFORMED);
      else a.value = p_nums[0];
    end
    if (p_err != ST_OK) a.value = '0;
    a.status = p_err;
    expected_answers.push_back(a);
    eval_clear();
  endtask

  // Stimulus helpers.
  task automatic send_char(logic [7:0] c, bit l);
    char_word_t w;
    w.sym = c;
    w.last = l;
    pending_chars.push_back(w);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] any_op();
    case ($urandom_range(0, 3))
      0: return CH_ADD;
      1: return CH_SUB;
      2: return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  task automatic send_number();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 3);
    for (int i = 0; i < n; i++) send_char(CH_ZERO + 8'($urandom_range(0, 9)), 0);
  endtask

  task automatic send_operand(int depth);
    if (depth < 3 && $urandom_range(0, 4) == 0) begin
      send_char(CH_LPAR, 0);
      send_expr(depth + 1);
      send_char(CH_RPAR, 0);
    end else send_number();
  endtask

  task automatic send_expr(int depth);
    int n;
    n = $urandom_range(0, 4);
    send_operand(depth);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_char(8'h20, 0);
      send_char(any_op(), 0);
      send_operand(depth);
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(0, 12);
    for (int i = 0; i < n; i++) send_char(8'($urandom_range(0, 255)), 0);
    send_char(8'($urandom_range(0, 255)), 1);
  endtask

  initial clk = 0;
  always #2 clk = ~clk;

  initial begin
    rst_n = 0;
    fail_count = 0;
    stimulus_done = 0;
    eval_clear();
    send_text("7");
    send_text("0");
    send_text("4294967295");
    send_text("2147483647+1");
    send_text("10-3-2");
    send_text("100/7/2");
    send_text("2+3*4");
    send_text("(2+3)*4");
    send_text("0-7/2");
    send_text("5/0");
    send_text("(0-2147483647-1)/(0-1)");
    send_text("99999999999");
    send_text("1 2");
    send_text("+");
    send_text("1+");
    send_text("3)");
    send_text("(3");
    send_text("a9b8~");
    send_char(8'hFF, 1);
    send_char(8'h80, 1);
    for (int i = 0; i < 130; i++) send_char(CH_LPAR, 0);
    send_text("1");
    for (int i = 0; i < 130; i++) send_char(CH_ZERO + 8'(i % 10), 0);
    send_text("1");
    while (pending_chars.size() < 1100) begin
      if ($urandom_range(0, 9) < 8) begin
        send_expr(0);
        if ($urandom_range(0, 1)) send_char(CH_RPAR, 1);
        else send_char(8'h3B, 1);
      end else send_noise();
    end
    repeat (12) @(posedge clk);
    rst_n <= 1;
  end

  // Sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= '0;
      in_tlast <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        eval_char({in_tdata, in_tlast});
      end
      if (!in_tvalid || in_tready) begin
        if (pending_chars.size() > 0 && (calm_phase || $urandom_range(0, 99) >= 19)) begin
          in_tvalid <= 1;
          {in_tdata, in_tlast} <= pending_chars.pop_front();
        end else begin
          in_tvalid <= 0;
          if (pending_chars.size() == 0) stimulus_done <= 1;
        end
      end
    end
  end

  // Receiver, with a quiet stretch and one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
      cycle_count <= 0;
      calm_phase <= 0;
      hold_cycles <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      calm_phase <= cycle_count > 2000 && cycle_count < 6000;
      if (cycle_count == 1000) hold_cycles <= 1500;
      else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      out_tready <= hold_cycles <= 1 && cycle_count != 1000 &&
                    (calm_phase || $urandom_range(0, 99) >= 19);
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        fail_count++;
      end else begin
        want = expected_answers.pop_front();
        if (out_tdata[31:0] !== want.value) begin
          $error("value: expected %h actual %h", want.value, out_tdata[31:0]);
          fail_count++;
        end
        if (out_tdata[33:32] !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, out_tdata[33:32]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    wait (rst_n);
    fork
      begin
        wait (stimulus_done && !in_tvalid && expected_answers.size() == 0);
        repeat (200) @(posedge clk);
      end
      begin
        wait (cycle_count >= 2000000);
        $display("Simulation FAILED");
        $finish;
      end
    join_any
    if (fail_count == 0 && expected_answers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
